### rtl/core/cddc_pkg.sv
package cddc_pkg;

    localparam int EPOCH_YEAR = 1970;
    localparam int MAX_YEAR   = 4095;

    localparam int YW    = 12;   // year
    localparam int MW    = 4;    // month
    localparam int DW    = 5;    // day of month
    localparam int STEPW = 16;   // day step
    localparam int CNTW  = 20;   // epoch day count
    localparam int WDW   = 17;   // working day count during an add
    localparam int QW    = 6;    // year / 100 for a 12-bit year
    localparam int RW    = 7;    // year % 100

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 4096
    localparam int RECIP100    = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 13;

    localparam int LEAPS_EPOCH = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                               + (EPOCH_YEAR - 1) / 400;
    localparam int EPOCH_R100  = EPOCH_YEAR % 100;
    localparam int EPOCH_Q4    = (EPOCH_YEAR / 100) % 4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DATE = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [MW-1:0] MON_JAN = 4'd1;
    localparam logic [MW-1:0] MON_FEB = 4'd2;
    localparam logic [MW-1:0] MON_DEC = 4'd12;

    localparam logic FUNC_SET = 1'b0;
    localparam logic FUNC_ADD = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the input transfer
        logic mul_q;     // year / 100
        logic mul_qx;    // (year - 1) / 100
        logic mul_qx4;   // (year - 1) / 400
        logic set_res;   // remainders, year days, leap count
        logic set_chk;   // validate and commit a set
        logic add_step;  // one month or one year of an add
        logic emit;      // load the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic add_fin;   // add finished this cycle
    } t_sts;

    function automatic logic [QW-1:0] div100(input logic [YW-1:0] x);
        logic [YW+RECIP_W-1:0] prod;
        prod = (YW+RECIP_W)'(x) * (YW+RECIP_W)'(RECIP100);
        return prod[RECIP_SHIFT +: QW];
    endfunction

    function automatic logic is_leap(input logic [1:0] y_low, input logic [RW-1:0] r100,
                                     input logic [1:0] q4);
        return (y_low == 2'd0) && ((r100 != '0) || (q4 == 2'd0));
    endfunction

    function automatic logic [DW-1:0] month_len(input logic [MW-1:0] m, input logic leap);
        logic [DW-1:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] month_base(input logic [MW-1:0] m);
        logic [8:0] base;
        unique case (m)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

### rtl/core/cddc_ctrl.sv
module cddc_ctrl
    import cddc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_func,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_Q1   = 8'b00000010,
        S_Q2   = 8'b00000100,
        S_Q3   = 8'b00001000,
        S_RES  = 8'b00010000,
        S_CHK  = 8'b00100000,
        S_ADD  = 8'b01000000,
        S_DONE = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_func == FUNC_ADD) ? S_ADD : S_Q1;
                end
            end
            S_Q1: begin
                o_cmd.mul_q = 1'b1;
                n_state     = S_Q2;
            end
            S_Q2: begin
                o_cmd.mul_qx = 1'b1;
                n_state      = S_Q3;
            end
            S_Q3: begin
                o_cmd.mul_qx4 = 1'b1;
                n_state       = S_RES;
            end
            S_RES: begin
                o_cmd.set_res = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                o_cmd.set_chk = 1'b1;
                n_state       = S_DONE;
            end
            S_ADD: begin
                o_cmd.add_step = 1'b1;
                if (i_sts.add_fin) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output slot frees
                if (slot_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/core/cddc_dp.sv
module cddc_dp
    import cddc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic [1:0]            o_out_status
);

    // stored date
    logic [YW-1:0]   r_year;
    logic [MW-1:0]   r_month;
    logic [DW-1:0]   r_day;
    logic [CNTW-1:0] r_total;
    logic [RW-1:0]   r_r100;
    logic [1:0]      r_q4;
    logic [1:0]      r_status;

    // captured input
    logic [YW-1:0]    r_yi;
    logic [MW-1:0]    r_mi;
    logic [DW-1:0]    r_di;
    logic [STEPW-1:0] r_step;

    // set path
    logic [QW-1:0]   r_q100, r_qx100, r_qx400;
    logic [RW-1:0]   r_s_r100;
    logic [1:0]      r_s_q4;
    logic [CNTW-1:0] r_ydays, r_leaps;

    // add path
    logic [YW-1:0]  r_w_year;
    logic [MW-1:0]  r_w_month;
    logic [WDW-1:0] r_w_day;
    logic [RW-1:0]  r_w_r100;
    logic [1:0]     r_w_q4;

    // output register
    logic [YW-1:0]   r_o_year;
    logic [MW-1:0]   r_o_month;
    logic [DW-1:0]   r_o_day;
    logic [CNTW-1:0] r_o_total;
    logic [1:0]      r_o_status;

    logic [YW-1:0]  in_year;
    logic [MW-1:0]  in_month;
    logic [DW-1:0]  in_day;
    logic [STEPW-1:0] in_step;

    assign in_year  = i_in_data[11:0];
    assign in_month = i_in_data[15:12];
    assign in_day   = i_in_data[20:16];
    assign in_step  = i_in_data[36:21];

    // shared divide-by-100 unit
    logic [YW-1:0] yi_m1, mul_in;
    logic [QW-1:0] mul_out;

    assign yi_m1 = r_yi - YW'(1);
    always_comb begin
        priority if (i_cmd.mul_q) begin
            mul_in = r_yi;
        end else if (i_cmd.mul_qx) begin
            mul_in = yi_m1;
        end else begin
            mul_in = {2'b00, yi_m1[YW-1:2]};
        end
    end
    assign mul_out = div100(mul_in);

    // remainders and year contribution
    logic [YW:0]   hund;
    logic [YW-1:0] rem100, yoff;
    assign hund   = (YW+1)'(r_q100) * (YW+1)'(100);
    assign rem100 = r_yi - hund[YW-1:0];
    assign yoff   = r_yi - YW'(EPOCH_YEAR);

    // set check
    logic          s_leap, s_ok;
    logic [DW-1:0] s_mlen;
    logic [CNTW-1:0] s_total;

    assign s_leap = is_leap(r_yi[1:0], r_s_r100, r_s_q4);
    assign s_mlen = month_len(r_mi, s_leap);
    assign s_ok   = (r_yi >= YW'(EPOCH_YEAR)) && ((YW+1)'(r_yi) <= (YW+1)'(MAX_YEAR))
                 && (r_mi >= MON_JAN) && (r_mi <= MON_DEC)
                 && (r_di != '0) && (r_di <= s_mlen);
    assign s_total = r_ydays + r_leaps + CNTW'(month_base(r_mi))
                   + CNTW'(s_leap && (r_mi > MON_FEB)) + CNTW'(r_di) - CNTW'(1);

    // add step: one year or one month per cycle
    logic          w_leap, y_over, a_year, a_month;
    logic [DW-1:0] w_mlen;
    logic [8:0]    w_ylen;
    logic [YW:0]   w_ynext;
    logic [RW-1:0] w_r100_next;
    logic [1:0]    w_q4_next;

    assign w_leap  = is_leap(r_w_year[1:0], r_w_r100, r_w_q4);
    assign w_mlen  = month_len(r_w_month, w_leap);
    assign w_ylen  = w_leap ? 9'd366 : 9'd365;
    assign w_ynext = (YW+1)'(r_w_year) + (YW+1)'(1);
    assign y_over  = w_ynext > (YW+1)'(MAX_YEAR);
    assign w_r100_next = (r_w_r100 == RW'(99)) ? '0 : r_w_r100 + RW'(1);
    assign w_q4_next   = (r_w_r100 == RW'(99)) ? r_w_q4 + 2'd1 : r_w_q4;
    assign a_year  = (r_w_month == MON_JAN) && (r_w_day > WDW'(w_ylen));
    assign a_month = r_w_day > WDW'(w_mlen);

    always_comb begin
        o_sts.add_fin = 1'b0;
        priority if (a_year) begin
            o_sts.add_fin = y_over;
        end else if (a_month) begin
            o_sts.add_fin = (r_w_month == MON_DEC) && y_over;
        end else begin
            o_sts.add_fin = 1'b1;
        end
    end

    // stored date and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= YW'(EPOCH_YEAR);
            r_month <= MON_JAN;
            r_day   <= DW'(1);
            r_total <= '0;
            r_r100  <= RW'(EPOCH_R100);
            r_q4    <= 2'(EPOCH_Q4);
        end else if (i_cmd.set_chk && s_ok) begin
            r_year  <= r_yi;
            r_month <= r_mi;
            r_day   <= r_di;
            r_total <= s_total;
            r_r100  <= r_s_r100;
            r_q4    <= r_s_q4;
        end else if (i_cmd.add_step && !a_year && !a_month) begin
            r_year  <= r_w_year;
            r_month <= r_w_month;
            r_day   <= r_w_day[DW-1:0];
            r_total <= r_total + CNTW'(r_step);
            r_r100  <= r_w_r100;
            r_q4    <= r_w_q4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_chk) begin
            r_status <= s_ok ? ST_OK : ST_BAD_DATE;
        end else if (i_cmd.add_step && o_sts.add_fin) begin
            r_status <= (a_year || a_month) ? ST_OVERFLOW : ST_OK;
        end
    end

    // input capture and set path
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_yi   <= in_year;
            r_mi   <= in_month;
            r_di   <= in_day;
            r_step <= in_step;
        end
        if (i_cmd.mul_q) begin
            r_q100 <= mul_out;
        end
        if (i_cmd.mul_qx) begin
            r_qx100 <= mul_out;
        end
        if (i_cmd.mul_qx4) begin
            r_qx400 <= mul_out;
        end
        if (i_cmd.set_res) begin
            r_s_r100 <= rem100[RW-1:0];
            r_s_q4   <= r_q100[1:0];
            r_ydays  <= CNTW'(yoff) * CNTW'(365);
            r_leaps  <= CNTW'(yi_m1[YW-1:2]) - CNTW'(r_qx100) + CNTW'(r_qx400)
                      - CNTW'(LEAPS_EPOCH);
        end
    end

    // working copy for an add
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w_year  <= r_year;
            r_w_month <= r_month;
            r_w_day   <= WDW'(r_day) + WDW'(in_step);
            r_w_r100  <= r_r100;
            r_w_q4    <= r_q4;
        end else if (i_cmd.add_step && !o_sts.add_fin) begin
            if (a_year) begin
                r_w_day  <= r_w_day - WDW'(w_ylen);
                r_w_year <= w_ynext[YW-1:0];
                r_w_r100 <= w_r100_next;
                r_w_q4   <= w_q4_next;
            end else begin
                r_w_day <= r_w_day - WDW'(w_mlen);
                if (r_w_month == MON_DEC) begin
                    r_w_month <= MON_JAN;
                    r_w_year  <= w_ynext[YW-1:0];
                    r_w_r100  <= w_r100_next;
                    r_w_q4    <= w_q4_next;
                end else begin
                    r_w_month <= r_w_month + MW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_year   <= r_year;
            r_o_month  <= r_month;
            r_o_day    <= r_day;
            r_o_total  <= r_total;
            r_o_status <= r_status;
        end
    end

    assign o_out_data   = {7'd0, r_o_total, r_o_day, r_o_month, r_o_year};
    assign o_out_status = r_o_status;

endmodule

### rtl/core/calendar_date_day_counter_top.sv
// Gregorian date counter. Holds a date and its day count since January 1 of
// 1970. A transfer with tuser 0 sets the date from year, month and day after
// checking it (status 1 on a bad date, stored date kept); a transfer with
// tuser 1 moves the date forward by day_step days (status 2 if the result
// would pass year 4095, stored date kept). Every input transfer yields one
// output transfer with the stored date, its day count and the status. One
// item is worked at a time. In a set the year is divided by 100 and 400
// through one shared reciprocal multiplier, one quotient per cycle, before
// the day count is summed and checked. An add steps one whole year at a time
// from a January and then one month at a time for each remaining month
// crossed. A new item is taken once the previous result sits in the output
// register, even if that result is still waiting.
module calendar_date_day_counter_top
    import cddc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [11:0] year_in, [15:12] month_in, [20:16] day_in, [36:21] day_step
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [11:0] year_out, [15:12] month_out, [20:16] day_out, [40:21] epoch_days
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]            m_axis_tuser
);

    t_cmd cmd;
    t_sts sts;

    // sequence the set and add operations
    cddc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_func   (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // date state, calendar arithmetic and the output register
    cddc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (s_axis_tdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser)
    );

endmodule
